>>> hdl/ufa_pkg.sv
package ufa_pkg;

    localparam logic [7:0]  HDR_LEN         = 8'd12;
    localparam int unsigned FID_BIT         = 0;
    localparam int unsigned ERR_BIT         = 6;
    localparam logic [23:0] FRAME_BYTES_RST = 24'd1228800;

    typedef enum logic [2:0] {
        ST_EMPTY    = 3'd0,
        ST_INVALID  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_PARTIAL  = 3'd3,
        ST_COMPLETE = 3'd4
    } t_status;

    typedef struct packed {
        logic [15:0] plen;
        logic [7:0]  hlen;
        logic [7:0]  info;
        logic [31:0] pts;
        logic [63:0] now;
    } t_pkt;

    typedef struct packed {
        logic        toggle;
        logic [23:0] bytes;
        logic [31:0] ts;
        logic [63:0] start;
        logic [63:0] interval;
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [23:0] woff;
        logic [15:0] wlen;
        logic        new_frame;
        logic        short_drop;
        logic        tchg;
        logic [31:0] ts;
        logic [63:0] interval;
    } t_res;

endpackage

>>> hdl/ufa_step.sv
module ufa_step (
    input  ufa_pkg::t_pkt   i_pkt,
    input  ufa_pkg::t_state i_state,
    input  logic [23:0]     i_frame_bytes,
    output ufa_pkg::t_state o_state,
    output ufa_pkg::t_res   o_res
);
    import ufa_pkg::*;

    logic        empty;
    logic        invalid;
    logic        toggle;
    logic [15:0] pay;
    logic [23:0] bc_eff;
    logic [24:0] sum;
    logic        overflow;

    assign empty    = (i_pkt.plen == 16'd0) || (i_pkt.plen == 16'(HDR_LEN));
    assign invalid  = (i_pkt.hlen != HDR_LEN) || (i_pkt.plen < 16'(HDR_LEN))
                      || i_pkt.info[ERR_BIT];
    assign toggle   = i_pkt.info[FID_BIT] != i_state.toggle;
    assign pay      = i_pkt.plen - 16'(HDR_LEN);
    assign bc_eff   = toggle ? 24'd0 : i_state.bytes;
    assign sum      = {1'b0, bc_eff} + {9'd0, pay};
    assign overflow = sum > {1'b0, i_frame_bytes};

    always_comb begin
        o_state          = i_state;
        o_res.status     = ST_EMPTY;
        o_res.woff       = 24'd0;
        o_res.wlen       = 16'd0;
        o_res.new_frame  = 1'b0;
        o_res.short_drop = 1'b0;
        o_res.tchg       = 1'b0;
        if (empty) begin
            o_res.status = ST_EMPTY;
        end else if (invalid) begin
            o_res.status = ST_INVALID;
        end else begin
            // presentation time is adopted on every good packet
            o_state.ts = i_pkt.pts;
            if (toggle) begin
                o_res.new_frame  = 1'b1;
                o_res.short_drop = i_state.bytes != i_frame_bytes;
                o_state.interval = i_pkt.now - i_state.start;
                o_state.toggle   = i_pkt.info[FID_BIT];
                o_state.start    = i_pkt.now;
            end else begin
                o_res.tchg = (i_state.bytes != 24'd0) && (i_pkt.pts != i_state.ts);
            end
            o_state.bytes = bc_eff;
            if (overflow) begin
                o_res.status = ST_OVERFLOW;
            end else begin
                o_res.woff    = bc_eff;
                o_res.wlen    = pay;
                o_state.bytes = sum[23:0];
                o_res.status  = (sum[23:0] == i_frame_bytes) ? ST_COMPLETE : ST_PARTIAL;
            end
        end
        o_res.ts       = o_state.ts;
        o_res.interval = o_state.interval;
    end

endmodule

>>> hdl/uvc_payload_frame_assembler.sv
// Packet descriptor in, DMA write descriptor out.
// Input channel (i_in_valid / o_in_ready) carries one isochronous packet
// descriptor per transaction: length, header length, header info byte,
// presentation time and arrival time.
// Output channel (o_out_valid / i_out_ready) returns one result per packet:
// status, write offset and length, frame start / short frame / time change
// flags, the frame time stamp and the last frame interval.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes frame_bytes; it is
// always ready. It is to be written only while no packet is in flight; the
// block itself does not enforce this. The result is registered: a packet goes
// through the input register, then the result register, which drives the output.
// Throughput: one packet per cycle while the receiver takes results; the frame
// state update between the two registers is combinational.
// Reset: frame state clears to zero, frame_bytes returns to 1228800, both
// pipeline registers empty.
// Receiver stall: the result register holds; one more packet is taken into
// the input register, after which o_in_ready drops until the result drains.
module uvc_payload_frame_assembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_packet_length,
    input  logic [7:0]  i_header_length,
    input  logic [7:0]  i_header_info,
    input  logic [31:0] i_presentation_time,
    input  logic [63:0] i_arrival_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [23:0] o_write_offset,
    output logic [15:0] o_write_length,
    output logic        o_new_frame,
    output logic        o_short_frame_dropped,
    output logic        o_time_changed_in_frame,
    output logic [31:0] o_frame_time_stamp,
    output logic signed [63:0] o_frame_interval,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_frame_bytes
);
    import ufa_pkg::*;

    t_pkt        r_in;
    logic        r_in_valid;
    t_state      r_state;
    t_state      n_state;
    logic [23:0] r_frame_bytes;
    t_res        r_res;
    t_res        n_res;
    logic        r_out_valid;
    logic        advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    ufa_step u_step (
        .i_pkt         (r_in),
        .i_state       (r_state),
        .i_frame_bytes (r_frame_bytes),
        .o_state       (n_state),
        .o_res         (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
            r_frame_bytes <= FRAME_BYTES_RST;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_frame_bytes <= i_cfg_frame_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.plen <= i_packet_length;
            r_in.hlen <= i_header_length;
            r_in.info <= i_header_info;
            r_in.pts  <= i_presentation_time;
            r_in.now  <= i_arrival_time;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_status                = r_res.status;
    assign o_write_offset          = r_res.woff;
    assign o_write_length          = r_res.wlen;
    assign o_new_frame             = r_res.new_frame;
    assign o_short_frame_dropped   = r_res.short_drop;
    assign o_time_changed_in_frame = r_res.tchg;
    assign o_frame_time_stamp      = r_res.ts;
    assign o_frame_interval        = r_res.interval;

    a_no_write_unless_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_res.status == ST_EMPTY || r_res.status == ST_INVALID
                        || r_res.status == ST_OVERFLOW)
        |-> o_write_length == 16'd0 && o_write_offset == 24'd0)
        else $error("write descriptor on rejected packet");

    a_short_needs_new_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_short_frame_dropped |-> o_new_frame)
        else $error("short frame flagged without frame start");

    a_tchg_not_on_new_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_time_changed_in_frame |-> !o_new_frame)
        else $error("time change flagged on frame start");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("result lost after advance");

    a_bytes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (n_res.status == ST_PARTIAL || n_res.status == ST_COMPLETE)
        |-> n_state.bytes <= r_frame_bytes)
        else $error("byte count beyond frame size");

endmodule
